[src/kvbrp_pkg.sv]
`default_nettype none
package kvbrp_pkg;

  localparam int unsigned HDR_BYTES   = 24;
  localparam int unsigned FLAGS_BYTES = 4;

  localparam int unsigned POS_W  = 33;
  localparam int unsigned IDX_W  = 5;

  // configuration register indexes
  localparam logic CFG_RESPONSE_MAGIC = 1'b0;
  localparam logic CFG_SUCCESS_STATUS = 1'b1;

  typedef enum logic [2:0] {
    SEG_HEADER  = 3'd0,
    SEG_EXTRAS  = 3'd1,
    SEG_KEY     = 3'd2,
    SEG_VALUE   = 3'd3,
    SEG_ERRTEXT = 3'd4,
    SEG_IGNORED = 3'd5
  } seg_t;

  typedef enum logic [2:0] {
    OC_OK         = 3'd0,
    OC_SHORT_HDR  = 3'd1,
    OC_BAD_MAGIC  = 3'd2,
    OC_TRUNCATED  = 3'd3,
    OC_LEN_INCONS = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [7:0]  magic;
    logic [15:0] success;
  } cfg_t;

  // one classified byte, handed from the front to the back
  typedef struct packed {
    logic [7:0]       data;
    seg_t             seg;
    logic             last;
    outcome_t         oc;
    logic             hdr_we;
    logic [IDX_W-1:0] hdr_idx;
    logic             flag_we;
    logic [1:0]       flag_idx;
  } entry_t;

endpackage
`default_nettype wire

[src/kv_binary_response_parser_core.sv]
`default_nettype none
// binary key-value response parser: takes a response buffer one byte per
// transaction (last_byte marks its final byte) and returns one transaction
// per byte carrying the byte, its segment tag (header, extras, key, value,
// error text or ignored) and, on the last byte, done_res with the outcome
// and, when the outcome is ok, the decoded header words, flags and value
// length; sustained rate is one byte per clock while results are popped, a
// byte passes through the queue and then the back's output register before
// it shows on the result ports, and the path is the front's position
// counter with its length compares feeding a short queue ahead of the
// back's header capture and output register; parsing restarts at header
// byte zero after each last byte and there is no startup clearing pass
module kv_binary_response_parser_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_data,
  // input side
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  // result side
  input  wire logic        pop,
  output logic             empty,
  output logic [2:0]       segment,
  output logic [7:0]       byte_out,
  output logic             done_res,
  output logic [2:0]       outcome,
  output logic [7:0]       opcode_out,
  output logic [15:0]      status_out,
  output logic [31:0]      opaque_out,
  output logic [63:0]      cas_out,
  output logic [31:0]      flags_out,
  output logic [15:0]      key_len_out,
  output logic [31:0]      value_len_out
);

  kvbrp_pkg::cfg_t   cfg;
  kvbrp_pkg::entry_t f_entry;
  kvbrp_pkg::entry_t q_entry;
  logic              take;
  logic              q_empty;
  logic              q_take;

  // a byte transaction completes when push meets a non-full queue
  assign take = push && !full;

  // configuration registers: the user writes them only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic   <= 8'h81;
      cfg.success <= 16'h0000;
    end else if (cfg_we) begin
      case (cfg_addr)
        kvbrp_pkg::CFG_RESPONSE_MAGIC: cfg.magic   <= cfg_data[7:0];
        kvbrp_pkg::CFG_SUCCESS_STATUS: cfg.success <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: byte position, length fields, segment tag and outcome
  kvbrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .entry     (f_entry)
  );

  // decoupling queue between classification and reporting
  kvbrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (take),
    .wr_data (f_entry),
    .full    (full),
    .rd      (q_take),
    .rd_data (q_entry),
    .empty   (q_empty)
  );

  // back: header word capture and registered result transaction
  kvbrp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (!q_empty),
    .q_data        (q_entry),
    .q_take        (q_take),
    .pop           (pop),
    .empty         (empty),
    .segment       (segment),
    .byte_out      (byte_out),
    .done_res      (done_res),
    .outcome       (outcome),
    .opcode_out    (opcode_out),
    .status_out    (status_out),
    .opaque_out    (opaque_out),
    .cas_out       (cas_out),
    .flags_out     (flags_out),
    .key_len_out   (key_len_out),
    .value_len_out (value_len_out)
  );

endmodule
`default_nettype wire

[src/kvbrp_front.sv]
`default_nettype none
module kvbrp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire kvbrp_pkg::cfg_t cfg,
  input  wire logic            take,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output kvbrp_pkg::entry_t    entry
);

  logic [kvbrp_pkg::POS_W-1:0] pos;
  logic [kvbrp_pkg::POS_W-1:0] pos_next;
  logic [7:0]                  magic;
  logic [15:0]                 key_len;
  logic [7:0]                  extras_len;
  logic [15:0]                 status;
  logic [31:0]                 body_len;

  logic                        in_hdr;
  logic                        pos_sat;
  logic [kvbrp_pkg::POS_W-1:0] off;
  logic [16:0]                 ek;
  logic                        ek_over;
  logic                        magic_bad;
  kvbrp_pkg::seg_t             seg;
  kvbrp_pkg::outcome_t         oc;

  assign in_hdr    = (pos < kvbrp_pkg::POS_W'(kvbrp_pkg::HDR_BYTES));
  assign pos_sat   = &pos;
  assign off       = pos - kvbrp_pkg::POS_W'(kvbrp_pkg::HDR_BYTES);
  assign ek        = {1'b0, key_len} + {9'd0, extras_len};
  assign ek_over   = ({15'd0, ek} > body_len);
  assign magic_bad = (magic != cfg.magic);
  assign pos_next  = last_byte ? '0 : (pos_sat ? pos : pos + 1'b1);

  always_comb begin
    if (in_hdr) begin
      seg = kvbrp_pkg::SEG_HEADER;
    end else if (pos_sat || magic_bad || ek_over) begin
      seg = kvbrp_pkg::SEG_IGNORED;
    end else if (off < {25'd0, extras_len}) begin
      seg = kvbrp_pkg::SEG_EXTRAS;
    end else if (off < {16'd0, ek}) begin
      seg = kvbrp_pkg::SEG_KEY;
    end else if (off < {1'b0, body_len}) begin
      seg = (status != cfg.success) ? kvbrp_pkg::SEG_ERRTEXT : kvbrp_pkg::SEG_VALUE;
    end else begin
      seg = kvbrp_pkg::SEG_IGNORED;
    end
  end

  // outcome priority: short, magic, truncated, inconsistent lengths
  always_comb begin
    oc = kvbrp_pkg::OC_OK;
    if (last_byte) begin
      if (pos < kvbrp_pkg::POS_W'(kvbrp_pkg::HDR_BYTES - 1)) begin
        oc = kvbrp_pkg::OC_SHORT_HDR;
      end else if (magic_bad) begin
        oc = kvbrp_pkg::OC_BAD_MAGIC;
      end else if ({1'b0, pos} <
                   (34'(kvbrp_pkg::HDR_BYTES - 1) + {2'd0, body_len})) begin
        oc = kvbrp_pkg::OC_TRUNCATED;
      end else if (ek_over) begin
        oc = kvbrp_pkg::OC_LEN_INCONS;
      end
    end
  end

  always_comb begin
    entry.data     = data_byte;
    entry.seg      = seg;
    entry.last     = last_byte;
    entry.oc       = oc;
    entry.hdr_we   = in_hdr;
    entry.hdr_idx  = pos[kvbrp_pkg::IDX_W-1:0];
    entry.flag_we  = (seg == kvbrp_pkg::SEG_EXTRAS) &&
                     (extras_len >= 8'(kvbrp_pkg::FLAGS_BYTES)) &&
                     (off < kvbrp_pkg::POS_W'(kvbrp_pkg::FLAGS_BYTES));
    entry.flag_idx = off[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      pos <= pos_next;
    end
  end

  // header fields used for classification; every field is fully
  // rewritten before it is consulted, so no clearing between buffers
  always_ff @(posedge clk) begin
    if (take && in_hdr) begin
      case (pos[kvbrp_pkg::IDX_W-1:0]) inside
        5'd0:           magic            <= data_byte;
        5'd2:           key_len[15:8]    <= data_byte;
        5'd3:           key_len[7:0]     <= data_byte;
        5'd4:           extras_len       <= data_byte;
        5'd6:           status[15:8]     <= data_byte;
        5'd7:           status[7:0]      <= data_byte;
        [5'd8:5'd11]:   body_len[8*(3 - pos[1:0]) +: 8] <= data_byte;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    take && last_byte |=> pos == '0)
    else $error("position not restarted after last byte");
`endif

endmodule
`default_nettype wire

[src/kvbrp_queue.sv]
`default_nettype none
module kvbrp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire kvbrp_pkg::entry_t wr_data,
  output logic                   full,
  input  wire logic              rd,
  output kvbrp_pkg::entry_t      rd_data,
  output logic                   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  kvbrp_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

[src/kvbrp_back.sv]
`default_nettype none
module kvbrp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire kvbrp_pkg::entry_t q_data,
  output logic                   q_take,
  input  wire logic              pop,
  output logic                   empty,
  output logic [2:0]             segment,
  output logic [7:0]             byte_out,
  output logic                   done_res,
  output logic [2:0]             outcome,
  output logic [7:0]             opcode_out,
  output logic [15:0]            status_out,
  output logic [31:0]            opaque_out,
  output logic [63:0]            cas_out,
  output logic [31:0]            flags_out,
  output logic [15:0]            key_len_out,
  output logic [31:0]            value_len_out
);

  logic        out_valid;
  logic        report;

  logic [7:0]  opcode,     opcode_next;
  logic [15:0] key_len,    key_len_next;
  logic [7:0]  extras_len, extras_len_next;
  logic [15:0] status,     status_next;
  logic [31:0] body_len,   body_len_next;
  logic [31:0] opaque,     opaque_next;
  logic [63:0] cas,        cas_next;
  logic [31:0] flags,      flags_next;
  logic [16:0] ek_next;
  logic [2:0]  cas_lane;

  assign empty    = !out_valid;
  assign q_take   = q_valid && (!out_valid || pop);
  assign report   = q_data.last && (q_data.oc == kvbrp_pkg::OC_OK);
  assign cas_lane = 3'(5'd23 - q_data.hdr_idx);
  assign ek_next  = {1'b0, key_len_next} + {9'd0, extras_len_next};

  // header words as they stand once the incoming byte is taken in
  always_comb begin
    opcode_next     = opcode;
    key_len_next    = key_len;
    extras_len_next = extras_len;
    status_next     = status;
    body_len_next   = body_len;
    opaque_next     = opaque;
    cas_next        = cas;
    flags_next      = flags;
    if (q_data.hdr_we) begin
      case (q_data.hdr_idx) inside
        5'd1:          opcode_next        = q_data.data;
        5'd2:          key_len_next[15:8] = q_data.data;
        5'd3:          key_len_next[7:0]  = q_data.data;
        5'd4:          extras_len_next    = q_data.data;
        5'd6:          status_next[15:8]  = q_data.data;
        5'd7:          status_next[7:0]   = q_data.data;
        [5'd8:5'd11]:  body_len_next[8*(3 - q_data.hdr_idx[1:0]) +: 8] = q_data.data;
        [5'd12:5'd15]: opaque_next[8*(3 - q_data.hdr_idx[1:0]) +: 8]   = q_data.data;
        [5'd16:5'd23]: cas_next[8*cas_lane +: 8]                       = q_data.data;
        default: ;
      endcase
    end
    if (q_data.flag_we) begin
      flags_next[8*(3 - q_data.flag_idx) +: 8] = q_data.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      opcode     <= opcode_next;
      key_len    <= key_len_next;
      extras_len <= extras_len_next;
      status     <= status_next;
      body_len   <= body_len_next;
      opaque     <= opaque_next;
      cas        <= cas_next;
      flags      <= flags_next;

      segment       <= q_data.seg;
      byte_out      <= q_data.data;
      done_res      <= q_data.last;
      outcome       <= q_data.oc;
      opcode_out    <= report ? opcode_next : '0;
      status_out    <= report ? status_next : '0;
      opaque_out    <= report ? opaque_next : '0;
      cas_out       <= report ? cas_next : '0;
      key_len_out   <= report ? key_len_next : '0;
      flags_out     <= (report && (extras_len_next >= 8'(kvbrp_pkg::FLAGS_BYTES))) ?
                       flags_next : '0;
      value_len_out <= report ? (body_len_next - {15'd0, ek_next}) : '0;
    end
  end

`ifndef SYNTHESIS
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> outcome == kvbrp_pkg::OC_OK && cas_out == '0
                               && value_len_out == '0)
    else $error("report fields set on a byte without done");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(byte_out) && $stable(segment))
    else $error("stalled transaction changed");
`endif

endmodule
`default_nettype wire

[tb/kv_binary_response_parser_core_tb.sv]
module kv_binary_response_parser_core_tb;

  // one buffer byte waiting to be offered
  typedef struct {
    logic [7:0] data;
    logic       last;
  } buffer_byte_t;

  // everything the parser reports for one byte
  typedef struct packed {
    kvbrp_pkg::seg_t     seg;
    logic [7:0]          data;
    logic                done;
    kvbrp_pkg::outcome_t oc;
    logic [7:0]          opcode;
    logic [15:0]         status;
    logic [31:0]         opaque;
    logic [63:0]         cas;
    logic [31:0]         flags;
    logic [15:0]         key_len;
    logic [31:0]         value_len;
  } parse_result_t;

  localparam logic [kvbrp_pkg::POS_W-1:0] POS_LIMIT = '1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = kvbrp_pkg::CFG_RESPONSE_MAGIC;
  logic [15:0] cfg_data = 16'h0000;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [2:0]  segment;
  logic [7:0]  byte_out;
  logic        done_res;
  logic [2:0]  outcome;
  logic [7:0]  opcode_out;
  logic [15:0] status_out;
  logic [31:0] opaque_out;
  logic [63:0] cas_out;
  logic [31:0] flags_out;
  logic [15:0] key_len_out;
  logic [31:0] value_len_out;

  kv_binary_response_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .pop          (pop),
    .empty        (empty),
    .segment      (segment),
    .byte_out     (byte_out),
    .done_res     (done_res),
    .outcome      (outcome),
    .opcode_out   (opcode_out),
    .status_out   (status_out),
    .opaque_out   (opaque_out),
    .cas_out      (cas_out),
    .flags_out    (flags_out),
    .key_len_out  (key_len_out),
    .value_len_out(value_len_out)
  );

  always #5 clk = ~clk;

  // bytes still to be offered, and parse results still to arrive
  buffer_byte_t  byte_backlog[$];
  parse_result_t expected_results[$];
  logic [7:0]    buf_bytes[$];    // buffer under construction
  buffer_byte_t  next_byte;

  int queued_total = 0;
  int accepted_total = 0;
  int failures = 0;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold-off to back the block up
  logic long_hold = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  logic in_fire = 1'b0;

  // shadow of the configuration registers
  logic [7:0]  cfg_magic = 8'h81;
  logic [15:0] cfg_status = 16'h0000;

  // parser state mirror
  logic [kvbrp_pkg::POS_W-1:0] pos_q = '0;
  logic [7:0]                  magic_q = '0;
  logic [7:0]                  opcode_q = '0;
  logic [15:0]                 keylen_q = '0;
  logic [7:0]                  extlen_q = '0;
  logic [15:0]                 status_q = '0;
  logic [31:0]                 body_q = '0;
  logic [31:0]                 opaque_q = '0;
  logic [63:0]                 cas_q = '0;
  logic [31:0]                 flags_q = '0;
  logic                        finished_q = 1'b0;

  // advance the parser mirror by one byte and queue what it reports
  task parse_byte(input logic [7:0] b, input logic last);
    logic [kvbrp_pkg::POS_W-1:0] p;
    logic [kvbrp_pkg::POS_W-1:0] off;
    logic [kvbrp_pkg::POS_W:0]   size;
    logic [16:0]                 ek;
    parse_result_t               r;
    if (finished_q) begin
      // previous byte closed a buffer: start over
      pos_q = '0;
      magic_q = '0;
      opcode_q = '0;
      keylen_q = '0;
      extlen_q = '0;
      status_q = '0;
      body_q = '0;
      opaque_q = '0;
      cas_q = '0;
      flags_q = '0;
    end
    p = pos_q;
    ek = {1'b0, keylen_q} + {9'd0, extlen_q};
    r = '0;
    r.data = b;
    if (p < kvbrp_pkg::HDR_BYTES) begin
      r.seg = kvbrp_pkg::SEG_HEADER;
      // big-endian header capture
      case (p)
        0:       magic_q = b;
        1:       opcode_q = b;
        2, 3:    keylen_q = {keylen_q[7:0], b};
        4:       extlen_q = b;
        5:       ;  // data type is not kept
        6, 7:    status_q = {status_q[7:0], b};
        8, 9, 10, 11:   body_q = {body_q[23:0], b};
        12, 13, 14, 15: opaque_q = {opaque_q[23:0], b};
        default: cas_q = {cas_q[55:0], b};
      endcase
    end else if (p == POS_LIMIT || magic_q != cfg_magic || ek > body_q) begin
      r.seg = kvbrp_pkg::SEG_IGNORED;
    end else begin
      off = p - kvbrp_pkg::HDR_BYTES;
      if (off < extlen_q) begin
        r.seg = kvbrp_pkg::SEG_EXTRAS;
        if (extlen_q >= kvbrp_pkg::FLAGS_BYTES && off < kvbrp_pkg::FLAGS_BYTES)
          flags_q = {flags_q[23:0], b};
      end else if (off < ek) begin
        r.seg = kvbrp_pkg::SEG_KEY;
      end else if (off < body_q) begin
        r.seg = (status_q != cfg_status) ? kvbrp_pkg::SEG_ERRTEXT : kvbrp_pkg::SEG_VALUE;
      end else begin
        r.seg = kvbrp_pkg::SEG_IGNORED;
      end
    end
    if (pos_q != POS_LIMIT) pos_q = pos_q + 1'b1;
    if (last) begin
      size = p + 1'b1;
      r.done = 1'b1;
      if (size < kvbrp_pkg::HDR_BYTES)
        r.oc = kvbrp_pkg::OC_SHORT_HDR;
      else if (magic_q != cfg_magic)
        r.oc = kvbrp_pkg::OC_BAD_MAGIC;
      else if (size < kvbrp_pkg::HDR_BYTES + {1'b0, body_q})
        r.oc = kvbrp_pkg::OC_TRUNCATED;
      else if (ek > body_q)
        r.oc = kvbrp_pkg::OC_LEN_INCONS;
      else
        r.oc = kvbrp_pkg::OC_OK;
      if (r.oc == kvbrp_pkg::OC_OK) begin
        r.opcode = opcode_q;
        r.status = status_q;
        r.opaque = opaque_q;
        r.cas = cas_q;
        r.flags = (extlen_q >= kvbrp_pkg::FLAGS_BYTES) ? flags_q : 32'h0;
        r.key_len = keylen_q;
        r.value_len = body_q - {15'd0, ek};
      end
    end
    finished_q = last;
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      failures++;
      if (failures < 50)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // input side: accept bookkeeping; result side: compare against the oldest expectation
  always @(posedge clk) begin
    parse_result_t want;
    in_fire <= !rst && push && !full;
    if (!rst && push && !full) begin
      parse_byte(data_byte, last_byte);
      accepted_total++;
    end
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: result transaction with nothing expected: expected none, actual byte %0h",
                 $time, byte_out);
      end else begin
        want = expected_results.pop_front();
        check_field("segment", want.seg, segment);
        check_field("byte_out", want.data, byte_out);
        check_field("done_res", want.done, done_res);
        check_field("outcome", want.oc, outcome);
        check_field("opcode_out", want.opcode, opcode_out);
        check_field("status_out", want.status, status_out);
        check_field("opaque_out", want.opaque, opaque_out);
        check_field("cas_out", want.cas, cas_out);
        check_field("flags_out", want.flags, flags_out);
        check_field("key_len_out", want.key_len, key_len_out);
        check_field("value_len_out", want.value_len, value_len_out);
      end
    end
  end

  // driver: keep a byte on the port until its transaction happens
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_fire) begin
      if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_byte = byte_backlog.pop_front();
        push <= 1'b1;
        data_byte <= next_byte.data;
        last_byte <= next_byte.last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: random pop, plus one long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold && !hold_taken) begin
      pop <= 1'b0;
      hold_left <= 80;
      hold_taken <= 1'b1;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    if (idx == kvbrp_pkg::CFG_RESPONSE_MAGIC) cfg_magic = val[7:0];
    else cfg_status = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task add_header(input logic [7:0] mg, input logic [7:0] op, input logic [15:0] klen,
                  input logic [7:0] elen, input logic [7:0] dtype, input logic [15:0] st,
                  input logic [31:0] body, input logic [31:0] opaque, input logic [63:0] cas);
    int i;
    buf_bytes.push_back(mg);
    buf_bytes.push_back(op);
    buf_bytes.push_back(klen[15:8]);
    buf_bytes.push_back(klen[7:0]);
    buf_bytes.push_back(elen);
    buf_bytes.push_back(dtype);
    buf_bytes.push_back(st[15:8]);
    buf_bytes.push_back(st[7:0]);
    for (i = 3; i >= 0; i--) buf_bytes.push_back(body[i*8 +: 8]);
    for (i = 3; i >= 0; i--) buf_bytes.push_back(opaque[i*8 +: 8]);
    for (i = 7; i >= 0; i--) buf_bytes.push_back(cas[i*8 +: 8]);
  endtask

  // hand the finished buffer to the driver, marking its final byte
  task flush_buffer;
    buffer_byte_t item;
    int i;
    for (i = 0; i < buf_bytes.size(); i++) begin
      item.data = buf_bytes[i];
      item.last = (i == buf_bytes.size() - 1);
      byte_backlog.push_back(item);
      queued_total++;
    end
    buf_bytes.delete();
  endtask

  // mostly well-formed responses with random content; the rest truncated,
  // wrong magic, inconsistent lengths, short headers and plain noise
  task make_random_buffer;
    int          kind;
    int          n;
    int          i;
    logic [15:0] klen;
    logic [7:0]  elen;
    logic [31:0] vlen;
    logic [31:0] body;
    logic [31:0] lim;
    logic [15:0] st;
    logic [7:0]  mg;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      // short header, or noise that may be long enough
      n = (kind < 95) ? $urandom_range(1, 23) : $urandom_range(24, 40);
      for (i = 0; i < n; i++) buf_bytes.push_back(8'($urandom));
      if (kind >= 95 && $urandom_range(0, 1) == 1) buf_bytes[0] = cfg_magic;
    end else begin
      mg = cfg_magic;
      klen = 16'($urandom_range(0, 6));
      elen = ($urandom_range(0, 3) == 0) ? 8'd4 : 8'($urandom_range(0, 8));
      vlen = $urandom_range(0, 10);
      st = ($urandom_range(0, 1) == 1) ? cfg_status : 16'($urandom);
      if (kind >= 60 && kind < 70) vlen = vlen + 1;
      body = elen + klen + vlen;
      if (kind >= 70 && kind < 80) mg = cfg_magic ^ 8'($urandom_range(1, 255));
      if (kind >= 80) begin
        // extras plus key beyond the body length
        if ($urandom_range(0, 1) == 1) klen = 16'($urandom_range(1, 65535));
        else klen = klen + 1'b1;
        lim = elen + klen - 1;
        if (lim > 20) lim = 20;
        body = $urandom_range(0, lim);
      end
      add_header(mg, 8'($urandom), klen, elen, 8'($urandom), st, body, $urandom,
                 {$urandom, $urandom});
      n = body + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      for (i = 0; i < n; i++) buf_bytes.push_back(8'($urandom));
      if (kind >= 60 && kind < 70) begin
        n = $urandom_range(24, 23 + body);
        while (buf_bytes.size() > n) void'(buf_bytes.pop_back());
      end
    end
    flush_buffer();
  endtask

  task queue_random_bytes(input int count);
    int target;
    target = queued_total + count;
    while (queued_total < target) make_random_buffer();
  endtask

  task wait_drained;
    while (accepted_total != queued_total || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // run limit
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (13) @(negedge clk);
    rst <= 1'b0;

    // directed: one-byte buffer, then a bare header with opcode, opaque, cas all ones
    send_idle_pct = 34;
    recv_idle_pct = 52;
    buf_bytes.push_back(8'hFF);
    flush_buffer();
    add_header(cfg_magic, 8'hFF, 16'h0000, 8'h00, 8'hFF, cfg_status, 32'h0,
               32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    flush_buffer();
    wait_drained();

    // low extremes of the magic, high of the status word
    write_reg(kvbrp_pkg::CFG_RESPONSE_MAGIC, 16'h0000);
    write_reg(kvbrp_pkg::CFG_SUCCESS_STATUS, 16'hFFFF);
    queue_random_bytes(120);
    wait_drained();

    // swapped idling, opposite extremes
    send_idle_pct = 52;
    recv_idle_pct = 34;
    write_reg(kvbrp_pkg::CFG_RESPONSE_MAGIC, 16'h00FF);
    write_reg(kvbrp_pkg::CFG_SUCCESS_STATUS, 16'h0000);
    queue_random_bytes(120);
    wait_drained();

    // full speed with one long receiver stall to fill the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(kvbrp_pkg::CFG_RESPONSE_MAGIC, 16'h0081);
    write_reg(kvbrp_pkg::CFG_SUCCESS_STATUS, 16'($urandom_range(1, 65534)));
    long_hold = 1'b1;
    queue_random_bytes(120);
    wait_drained();

    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
